FILE: rtl/core/power_mutation_top_macros.svh
// Assertion macros shared by the power mutation checkers
`ifndef POWER_MUTATION_TOP_MACROS_SVH
`define POWER_MUTATION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define PM_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pwr_mut_pkg.sv
// Types, constants and table builders for the power mutation block
package pwr_mut_pkg;

    localparam int MAX_TABLE_BITS = 10;
    localparam logic [15:0] INV_EXP_RESET = 16'd256;
    localparam logic [15:0] STEP_MAX = 16'hFFFF;
    localparam logic [12:0] EXP_SHIFT_LIMIT = 13'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_LMUL,
        S_LOGF,
        S_PMUL,
        S_EXPL,
        S_EMUL,
        S_EXPF,
        S_TEST,
        S_DECIDE,
        S_SMUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic [15:0]        scale_draw;
        logic [15:0]        side_draw;
        logic               first_coordinate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] mutated_position;
        logic               moved_down;
    } t_out_item;

    // log2(1 + idx/2^bits) in Q16, bit by bit from repeated Q30 squaring
    function automatic logic [16:0] log_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] x;
        logic [16:0] acc;
        x = (64'd1 << 30) + (64'(idx) << (30 - bits));
        acc = '0;
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            acc = {acc[15:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                acc[0] = 1'b1;
                x = x >> 1;
            end
        end
        if (idx == (32'd1 << bits)) begin
            acc = 17'd65536;
        end
        return acc;
    endfunction

    // Truncating integer square root, two bits a round
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v = v_in;
        res = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-idx/2^bits) in Q16, built from products of Q30 roots of one half
    function automatic logic [16:0] exp_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] roots [0:MAX_TABLE_BITS];
        logic [63:0] p;
        logic [16:0] ret;
        roots[0] = 64'd1 << 29;
        for (int k = 1; k <= MAX_TABLE_BITS; k++) begin
            roots[k] = '0;
            if (k <= int'(bits)) begin
                roots[k] = isqrt64(roots[k - 1] << 30);
            end
        end
        p = 64'd1 << 30;
        for (int k = 1; k <= MAX_TABLE_BITS; k++) begin
            if (k <= int'(bits)) begin
                if (((idx >> (bits - k)) & 32'd1) != 0) begin
                    p = (p * roots[k]) >> 30;
                end
            end
        end
        ret = 17'((p + (64'd1 << 13)) >> 14);
        if (idx == (32'd1 << bits)) begin
            ret = 17'd32768;
        end
        return ret;
    endfunction

endpackage

FILE: rtl/core/power_mutation_top.sv
// Power mutation core: step generation and per-coordinate position update
// Power mutation of a real-coded vector, one coordinate per input beat. A beat
// marked first_coordinate recomputes the step s = u^(1/p) from scale_draw as
// 2^-(inverse_exponent * -log2 u), using interpolated log2 and exp2 tables;
// s is zero for a zero draw and stays zero until a first coordinate arrives.
// Each coordinate then tests (x - lo)/(hi - x) < side_draw by cross-
// multiplication and moves toward lo by s*(x - lo) or toward hi by
// s*(hi - x); moved_down reports the direction. Positions are signed Q16.16,
// draws and s unsigned Q0.16, inverse_exponent unsigned Q8.8 (reset 1.0).
// Sequencing: every arithmetic step shares one 33x16 multiplier under a small
// sequencer, with the product registered, so the block takes one beat at a
// time. An ordinary coordinate passes S_TEST, S_DECIDE, S_SMUL and S_DONE and
// loads the result register as it returns to S_IDLE to take the next beat. A
// first coordinate first computes the step in S_LOOK to S_EXPF (log lookup,
// log interpolation, exponent multiply, exp interpolation); it jumps to S_TEST
// with a zero step from S_EXPL when the integer part of the exponent exceeds
// 16, or from S_LOOK when the draw is zero. The result sits in an output
// register, so a stalled result does not block the next input beat; only the
// following result waits for it to be taken before it loads. Write
// inverse_exponent only while the block is idle.
module power_mutation_top #(
    parameter int LOG_TABLE_BITS = 6,
    parameter int EXP_TABLE_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  pwr_mut_pkg::t_in_item  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pwr_mut_pkg::t_out_item o_data,
    input  logic                  i_cfg_wr_en,
    input  logic [15:0]           i_cfg_wr_data
);

    localparam int LOG_SIZE = 1 << LOG_TABLE_BITS;
    localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;
    localparam int LSH = 15 - LOG_TABLE_BITS;
    localparam int ESH = 16 - EXP_TABLE_BITS;

    // Index of the highest set bit; the draw is known nonzero where used
    function automatic logic [3:0] msb_index(input logic [15:0] v);
        logic [3:0] idx;
        idx = '0;
        for (int k = 0; k < 16; k++) begin
            if (v[k]) begin
                idx = 4'(k);
            end
        end
        return idx;
    endfunction

    // Constant tables, built at elaboration
    logic [16:0] w_lt [0:LOG_SIZE];
    logic [16:0] w_et [0:EXP_SIZE];

    for (genvar gi = 0; gi <= LOG_SIZE; gi++) begin : g_lt
        localparam logic [16:0] LT_V = pwr_mut_pkg::log_entry(gi, LOG_TABLE_BITS);
        assign w_lt[gi] = LT_V;
    end

    for (genvar gj = 0; gj <= EXP_SIZE; gj++) begin : g_et
        localparam logic [16:0] ET_V = pwr_mut_pkg::exp_entry(gj, EXP_TABLE_BITS);
        assign w_et[gj] = ET_V;
    end

    // Control state
    pwr_mut_pkg::t_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_step, n_step;
    logic [15:0] r_inv_exp;

    // Datapath registers
    logic signed [31:0] r_x, n_x;
    logic signed [32:0] r_dlo, n_dlo;
    logic signed [32:0] r_dhi, n_dhi;
    logic [15:0] r_side, n_side;
    logic [15:0] r_u, n_u;
    logic [16:0] r_base, n_base;
    logic [32:0] r_opa, n_opa;
    logic [15:0] r_opb, n_opb;
    logic [48:0] r_prod;
    logic [3:0]  r_m, n_m;
    logic [4:0]  r_ip, n_ip;
    logic        r_down, n_down;
    logic        r_neg, n_neg;
    pwr_mut_pkg::t_out_item r_out_data, n_out_data;

    // Shared multiplier
    logic [48:0] w_prod;
    assign w_prod = {16'b0, r_opa} * {33'b0, r_opb};

    // Input differences, formed on the accepted beat
    logic signed [32:0] w_dlo_in, w_dhi_in;
    assign w_dlo_in = {i_data.position[31], i_data.position}
                    - {i_data.lower_bound[31], i_data.lower_bound};
    assign w_dhi_in = {i_data.upper_bound[31], i_data.upper_bound}
                    - {i_data.position[31], i_data.position};

    // Log table lookup from the normalised draw
    logic [3:0]                  w_m;
    logic [15:0]                 w_norm;
    logic [LOG_TABLE_BITS-1:0]   w_lidx;
    logic [LOG_TABLE_BITS:0]     w_lidx_nx;
    logic [LSH-1:0]              w_lrem;
    logic [16:0]                 w_lt_lo, w_lt_hi;
    assign w_m       = msb_index(r_u);
    assign w_norm    = r_u << (4'd15 - w_m);
    assign w_lidx    = w_norm[14:LSH];
    assign w_lrem    = w_norm[LSH-1:0];
    assign w_lidx_nx = {1'b0, w_lidx} + 1'b1;
    assign w_lt_lo   = w_lt[{1'b0, w_lidx}];
    assign w_lt_hi   = w_lt[w_lidx_nx];

    // -log2 u in Q16
    logic [16:0] w_log;
    logic [20:0] w_neg;
    assign w_log = r_base + 17'(r_prod >> LSH);
    assign w_neg = {5'd16 - {1'b0, r_m}, 16'b0} - {4'b0, w_log};

    // Exponent split and exp table lookup
    logic [28:0]               w_t;
    logic [12:0]               w_ip;
    logic [EXP_TABLE_BITS-1:0] w_eidx;
    logic [EXP_TABLE_BITS:0]   w_eidx_nx;
    logic [ESH-1:0]            w_erem;
    logic [16:0]               w_et_lo, w_et_hi;
    assign w_t       = r_prod[36:8];
    assign w_ip      = w_t[28:16];
    assign w_eidx    = w_t[15:ESH];
    assign w_erem    = w_t[ESH-1:0];
    assign w_eidx_nx = {1'b0, w_eidx} + 1'b1;
    assign w_et_lo   = w_et[{1'b0, w_eidx}];
    assign w_et_hi   = w_et[w_eidx_nx];

    // Interpolated exp, integer shift and saturation
    logic [16:0] w_e, w_e_sh;
    logic [15:0] w_step_new;
    assign w_e        = r_base - 17'(r_prod >> ESH);
    assign w_e_sh     = w_e >> r_ip;
    assign w_step_new = (w_e_sh > 17'd65535) ? pwr_mut_pkg::STEP_MAX : w_e_sh[15:0];

    // Direction test: hi - x > 0 and (x - lo) * 2^16 < r * (hi - x)
    logic               w_down;
    logic signed [32:0] w_d;
    logic [32:0]        w_mag;
    assign w_down = !r_dhi[32] && (r_dhi != '0)
                 && ($signed({r_dlo[32], r_dlo, 16'b0}) < $signed({1'b0, r_prod}));
    assign w_d    = w_down ? r_dlo : r_dhi;
    assign w_mag  = w_d[32] ? 33'(-w_d) : 33'(w_d);

    // Position update from the scaled distance
    logic [32:0] w_scaled, w_delta, w_res;
    assign w_scaled = r_prod[48:16];
    assign w_delta  = r_neg ? 33'(-w_scaled) : w_scaled;
    assign w_res    = r_down ? ({r_x[31], r_x} - w_delta) : ({r_x[31], r_x} + w_delta);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_step      = r_step;
        n_x         = r_x;
        n_dlo       = r_dlo;
        n_dhi       = r_dhi;
        n_side      = r_side;
        n_u         = r_u;
        n_base      = r_base;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_m         = r_m;
        n_ip        = r_ip;
        n_down      = r_down;
        n_neg       = r_neg;

        // Drop the result once the downstream side takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pwr_mut_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_x    = i_data.position;
                    n_dlo  = w_dlo_in;
                    n_dhi  = w_dhi_in;
                    n_side = i_data.side_draw;
                    n_u    = i_data.scale_draw;
                    if (i_data.first_coordinate) begin
                        n_state = pwr_mut_pkg::S_LOOK;
                    end else begin
                        n_opa   = 33'(w_dhi_in);
                        n_opb   = i_data.side_draw;
                        n_state = pwr_mut_pkg::S_TEST;
                    end
                end
            end
            pwr_mut_pkg::S_LOOK: begin
                if (r_u == '0) begin
                    n_step  = '0;
                    n_opa   = 33'(r_dhi);
                    n_opb   = r_side;
                    n_state = pwr_mut_pkg::S_TEST;
                end else begin
                    n_m     = w_m;
                    n_base  = w_lt_lo;
                    n_opa   = {16'b0, w_lt_hi - w_lt_lo};
                    n_opb   = 16'(w_lrem);
                    n_state = pwr_mut_pkg::S_LMUL;
                end
            end
            pwr_mut_pkg::S_LMUL: begin
                n_state = pwr_mut_pkg::S_LOGF;
            end
            pwr_mut_pkg::S_LOGF: begin
                n_opa   = {12'b0, w_neg};
                n_opb   = r_inv_exp;
                n_state = pwr_mut_pkg::S_PMUL;
            end
            pwr_mut_pkg::S_PMUL: begin
                n_state = pwr_mut_pkg::S_EXPL;
            end
            pwr_mut_pkg::S_EXPL: begin
                if (w_ip > pwr_mut_pkg::EXP_SHIFT_LIMIT) begin
                    n_step  = '0;
                    n_opa   = 33'(r_dhi);
                    n_opb   = r_side;
                    n_state = pwr_mut_pkg::S_TEST;
                end else begin
                    n_ip    = w_ip[4:0];
                    n_base  = w_et_lo;
                    n_opa   = {16'b0, w_et_lo - w_et_hi};
                    n_opb   = 16'(w_erem);
                    n_state = pwr_mut_pkg::S_EMUL;
                end
            end
            pwr_mut_pkg::S_EMUL: begin
                n_state = pwr_mut_pkg::S_EXPF;
            end
            pwr_mut_pkg::S_EXPF: begin
                n_step  = w_step_new;
                n_opa   = 33'(r_dhi);
                n_opb   = r_side;
                n_state = pwr_mut_pkg::S_TEST;
            end
            pwr_mut_pkg::S_TEST: begin
                n_state = pwr_mut_pkg::S_DECIDE;
            end
            pwr_mut_pkg::S_DECIDE: begin
                n_down  = w_down;
                n_neg   = w_d[32];
                n_opa   = w_mag;
                n_opb   = r_step;
                n_state = pwr_mut_pkg::S_SMUL;
            end
            pwr_mut_pkg::S_SMUL: begin
                n_state = pwr_mut_pkg::S_DONE;
            end
            pwr_mut_pkg::S_DONE: begin
                // Hold here while the output register still holds an untaken beat
                if (!r_out_valid || !i_stall) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.mutated_position = w_res[31:0];
                    n_out_data.moved_down       = r_down;
                    n_state                     = pwr_mut_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pwr_mut_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwr_mut_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_inv_exp   <= pwr_mut_pkg::INV_EXP_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            if (i_cfg_wr_en) begin
                r_inv_exp <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_dlo      <= n_dlo;
        r_dhi      <= n_dhi;
        r_side     <= n_side;
        r_u        <= n_u;
        r_base     <= n_base;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_prod     <= w_prod;
        r_m        <= n_m;
        r_ip       <= n_ip;
        r_down     <= n_down;
        r_neg      <= n_neg;
        r_out_data <= n_out_data;
    end

    assign o_stall = (r_state != pwr_mut_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/core/pwr_mut_chk.sv
// Port-level checker for the power mutation core, with its bind
`include "power_mutation_top_macros.svh"

module pwr_mut_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input pwr_mut_pkg::t_out_item o_data
);

    // A stalled result stays put
    `PM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "result changed while stalled")

    // An accepted beat keeps the block busy on the next cycle
    `PM_ASSERT_NEXT(a_busy_after_beat, i_valid && !o_stall, o_stall, "block free right after accepting a beat")

    // A new result only appears out of a busy cycle
    `PM_ASSERT_NOW(a_result_from_work, $rose(o_valid), $past(o_stall), "result appeared without work in progress")

    // Reset leaves the block empty and ready
    `PM_ASSERT_RESET(a_reset_clears, !i_rst_n, !o_valid && !o_stall, "reset did not clear the block")

endmodule

bind power_mutation_top pwr_mut_chk u_pwr_mut_chk (.*);
